>>> hw/rtl/assert_macros.svh
// assertion helpers for the checker of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, idle during reset
`define PTK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define PTK_NEVER(label, cond, msg) \
  `PTK_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/ptk_pkg.sv
package ptk_pkg;

  localparam int CFG_IDX_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_R_XX     = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_R_XY     = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_R_YX     = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_R_YY     = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP     = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STANDOFF = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE    = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND = 4'd7;

  // operand / destination codes of the shared datapath
  typedef enum logic [5:0] {
    SRC_ZERO, SRC_MX, SRC_MY, SRC_EX, SRC_EY, SRC_VX, SRC_VY,
    SRC_XP, SRC_YP, SRC_IX, SRC_IY,
    SRC_G0, SRC_G1, SRC_G2, SRC_G3,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3,
    SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_ST,
    SRC_A0, SRC_A1, SRC_A2, SRC_A3, SRC_DET,
    SRC_N0, SRC_N1, SRC_N2, SRC_N3
  } src_e;

  // dst = sat(ia +/- ib +/- p0a*p0b +/- p1a*p1b)
  typedef struct packed {
    src_e       dst;
    src_e       ia;
    src_e       ib;
    logic       ib_neg;
    logic [1:0] nprod;
    src_e       p0a;
    src_e       p0b;
    logic       p0neg;
    src_e       p1a;
    src_e       p1b;
    logic       p1neg;
  } job_t;

  localparam int JOB_BITS = 5;
  localparam logic [JOB_BITS-1:0] JOB_LAST_PRE = 5'd14;
  localparam logic [JOB_BITS-1:0] JOB_FIRST_POST = 5'd15;
  localparam logic [JOB_BITS-1:0] JOB_LAST = 5'd18;

  function automatic job_t mk(src_e dst, src_e ia, src_e ib, logic ibn, logic [1:0] np,
                              src_e p0a, src_e p0b, logic p0n,
                              src_e p1a, src_e p1b, logic p1n);
    job_t j;
    j.dst = dst; j.ia = ia; j.ib = ib; j.ib_neg = ibn; j.nprod = np;
    j.p0a = p0a; j.p0b = p0b; j.p0neg = p0n;
    j.p1a = p1a; j.p1b = p1b; j.p1neg = p1n;
    return j;
  endfunction

  function automatic job_t job_of(logic [JOB_BITS-1:0] idx);
    job_t j;
    case (idx)
      5'd0:  j = mk(SRC_XP, SRC_EX, SRC_ZERO, 1'b0, 2'd1, SRC_VX, SRC_ST, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd1:  j = mk(SRC_YP, SRC_EY, SRC_ZERO, 1'b0, 2'd1, SRC_VY, SRC_ST, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd2:  j = mk(SRC_IX, SRC_MX, SRC_XP, 1'b1, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd3:  j = mk(SRC_IY, SRC_MY, SRC_YP, 1'b1, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd4:  j = mk(SRC_EX, SRC_XP, SRC_ZERO, 1'b0, 2'd2, SRC_G0, SRC_IX, 1'b0,
                    SRC_G1, SRC_IY, 1'b0);
      5'd5:  j = mk(SRC_EY, SRC_YP, SRC_ZERO, 1'b0, 2'd2, SRC_G2, SRC_IX, 1'b0,
                    SRC_G3, SRC_IY, 1'b0);
      5'd6:  j = mk(SRC_A0, SRC_P0, SRC_R0, 1'b0, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd7:  j = mk(SRC_A1, SRC_P1, SRC_R1, 1'b0, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd8:  j = mk(SRC_A2, SRC_P2, SRC_R2, 1'b0, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd9:  j = mk(SRC_A3, SRC_P3, SRC_R3, 1'b0, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                    SRC_ZERO, SRC_ZERO, 1'b0);
      5'd10: j = mk(SRC_DET, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_A0, SRC_A3, 1'b0,
                    SRC_A1, SRC_A2, 1'b1);
      5'd11: j = mk(SRC_N0, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_P0, SRC_A3, 1'b0,
                    SRC_P1, SRC_A2, 1'b1);
      5'd12: j = mk(SRC_N1, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_P1, SRC_A0, 1'b0,
                    SRC_P0, SRC_A1, 1'b1);
      5'd13: j = mk(SRC_N2, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_P2, SRC_A3, 1'b0,
                    SRC_P3, SRC_A2, 1'b1);
      5'd14: j = mk(SRC_N3, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_P3, SRC_A0, 1'b0,
                    SRC_P2, SRC_A1, 1'b1);
      5'd15: j = mk(SRC_P0, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_G0, SRC_R0, 1'b0,
                    SRC_G1, SRC_R2, 1'b0);
      5'd16: j = mk(SRC_P1, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_G0, SRC_R1, 1'b0,
                    SRC_G1, SRC_R3, 1'b0);
      5'd17: j = mk(SRC_P2, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_G2, SRC_R0, 1'b0,
                    SRC_G3, SRC_R2, 1'b0);
      5'd18: j = mk(SRC_P3, SRC_ZERO, SRC_ZERO, 1'b0, 2'd2, SRC_G2, SRC_R1, 1'b0,
                    SRC_G3, SRC_R3, 1'b0);
      default: j = mk(SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 2'd0, SRC_ZERO, SRC_ZERO, 1'b0,
                      SRC_ZERO, SRC_ZERO, 1'b0);
    endcase
    return j;
  endfunction

endpackage

>>> hw/rtl/ptk_mul.sv
module ptk_mul import ptk_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        sat_o
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W + 1;

  localparam logic [PW-1:0] HALF    = {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [PW-1:0] POS_LIM = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] NEG_LIM = {{(W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   mag_a, mag_b;
  logic [2*W-1:0] prod_q;
  logic           neg_q;
  logic [PW-1:0]  rnd;

  assign mag_a = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mag_b = b_i[W-1] ? W'(-b_i) : W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= mag_a * mag_b;
    neg_q  <= a_i[W-1] ^ b_i[W-1];
  end

  // round half away from zero on the magnitude, then clip to the word
  always_comb begin
    rnd = ({1'b0, prod_q} + HALF) >> FRAC_BITS;
    if (neg_q) begin
      sat_o = rnd > NEG_LIM;
      res_o = sat_o ? {1'b1, {(W-1){1'b0}}} : -$signed(rnd[W-1:0]);
    end else begin
      sat_o = rnd > POS_LIM;
      res_o = sat_o ? {1'b0, {(W-1){1'b1}}} : $signed(rnd[W-1:0]);
    end
  end

endmodule

>>> hw/rtl/ptk_div.sv
module ptk_div import ptk_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] num_i,
  input  logic signed [WORD_BITS-1:0] den_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        sat_o
);

  localparam int W  = WORD_BITS;
  localparam int L  = W + FRAC_BITS + 1;
  localparam int CW = $clog2(L + 1);

  localparam logic [W:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e           st_q;
  logic [CW-1:0]     cnt_q;
  logic [L-1:0]      dvd_q, quo_q;
  logic [W-1:0]      rem_q, den_q;
  logic              neg_q, zden_q, nneg_q, nzero_q;
  logic [W-1:0]      mag_n, mag_d;
  logic [W:0]        trial;
  logic              ge;
  logic [W+1:0]      rsum;
  logic [W:0]        mag;
  logic              ovf;
  logic signed [W-1:0] fin_res;
  logic              fin_sat;

  assign mag_n = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign mag_d = den_i[W-1] ? W'(-den_i) : W'(den_i);
  assign trial = {rem_q, dvd_q[L-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rsum = {1'b0, quo_q[W:0]} + {{(W+1){1'b0}}, 1'b1};
    mag  = rsum[W+1:1];
    ovf  = |quo_q[L-1:W+1];
    if (zden_q) begin
      fin_sat = 1'b1;
      fin_res = nzero_q ? '0 : (nneg_q ? MINV : MAXV);
    end else if (neg_q) begin
      fin_sat = ovf || (mag > NEG_LIM);
      fin_res = fin_sat ? MINV : -$signed(mag[W-1:0]);
    end else begin
      fin_sat = ovf || (mag > POS_LIM);
      fin_res = fin_sat ? MAXV : $signed(mag[W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        D_IDLE: begin
          if (start_i) begin
            dvd_q   <= {mag_n, {(FRAC_BITS+1){1'b0}}};
            quo_q   <= '0;
            rem_q   <= '0;
            den_q   <= mag_d;
            neg_q   <= num_i[W-1] ^ den_i[W-1];
            nneg_q  <= num_i[W-1];
            nzero_q <= num_i == '0;
            zden_q  <= den_i == '0;
            cnt_q   <= CW'(L);
            st_q    <= (den_i == '0) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
          quo_q <= {quo_q[L-2:0], ge};
          dvd_q <= {dvd_q[L-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            st_q <= D_FIN;
          end
        end
        D_FIN: begin
          res_o  <= fin_res;
          sat_o  <= fin_sat;
          done_o <= 1'b1;
          st_q   <= D_IDLE;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/position_kalman_tracker_2d.sv
// channel   direction  handshake                 payload
// in        to block   in_valid_i / in_ready_o   meas_x_i, meas_y_i
// out       from block out_valid_o / out_ready_i est_x_o, est_y_o, goal_forward_o,
//                                                too_close_o, saturated_o
// cfg       to block   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a request runs the 19 sum-of-products jobs on one shared registered multiplier
// and four gain divisions, each a bit a cycle, with far fewer steps on a zero determinant
// in_ready_o and cfg_ready_o are high only while the sequencer is idle
// a finished result sits in the output register, so a stalled out side does not stop
// the next request from being taken; only the write of a second result waits
// reset puts the filter state at its start values, no clearing pass
module position_kalman_tracker_2d import ptk_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] meas_x_i,
  input  logic signed [WORD_BITS-1:0] meas_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] est_x_o,
  output logic signed [WORD_BITS-1:0] est_y_o,
  output logic [WORD_BITS-2:0]        goal_forward_o,
  output logic                        too_close_o,
  output logic                        saturated_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [WORD_BITS-1:0]        cfg_data_i
);

  localparam int W  = WORD_BITS;
  localparam int AW = W + 3;   // accumulator: two terms plus two products

  localparam int ONE_I   = 1 << FRAC_BITS;
  localparam int TENTH_I = (ONE_I + 5) / 10;
  localparam int FIFTH_I = (2 * ONE_I + 5) / 10;
  localparam int HALF5_I = 5 * (ONE_I / 2);
  localparam int QUART3_I = 3 * (ONE_I / 4);

  localparam logic signed [W-1:0] ONE_W = {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] MAXA = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] MINA = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_INIT, S_MUL, S_ACC, S_WRITE, S_DIV_GO, S_DIV_WAIT, S_DONE
  } state_e;

  // configuration
  logic [W-2:0]        cfg_rxx_q, cfg_ryy_q, cfg_step_q, cfg_stand_q, cfg_close_q, cfg_dead_q;
  logic signed [W-1:0] cfg_rxy_q, cfg_ryx_q;

  // filter state
  logic signed [W-1:0] est_x_q, est_y_q, last_x_q, last_y_q;
  logic signed [W-1:0] gain_q [4];
  logic signed [W-1:0] cov_q [4];
  logic                seen_q;

  // per-request scratch
  logic signed [W-1:0] mx_q, my_q, vx_q, vy_q, xp_q, yp_q, ix_q, iy_q, det_q;
  logic signed [W-1:0] a_q [4];
  logic signed [W-1:0] num_q [4];
  logic signed [AW-1:0] acc_q;

  state_e              state_q;
  logic [JOB_BITS-1:0] job_q;
  logic                pidx_q;
  logic [1:0]          div_k_q;
  logic                sat_q;

  job_t                jb;
  logic signed [W-1:0] mul_a, mul_b, mul_res;
  logic                mul_sat, pneg;
  logic signed [AW-1:0] init_sum, dvx, dvy, prod_ext;
  logic                div_start, div_done, div_sat;
  logic signed [W-1:0] div_res;
  logic signed [W:0]   gdiff;
  logic [W-2:0]        goal;

  function automatic logic signed [W-1:0] clip(input logic signed [AW-1:0] v);
    if (v > MAXA) return {1'b0, {(W-1){1'b1}}};
    if (v < MINA) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  function automatic logic over(input logic signed [AW-1:0] v);
    return (v > MAXA) || (v < MINA);
  endfunction

  // operand read out of the named registers
  function automatic logic signed [W-1:0] pick(input src_e s);
    case (s)
      SRC_MX:  return mx_q;
      SRC_MY:  return my_q;
      SRC_EX:  return est_x_q;
      SRC_EY:  return est_y_q;
      SRC_VX:  return vx_q;
      SRC_VY:  return vy_q;
      SRC_XP:  return xp_q;
      SRC_YP:  return yp_q;
      SRC_IX:  return ix_q;
      SRC_IY:  return iy_q;
      SRC_G0:  return gain_q[0];
      SRC_G1:  return gain_q[1];
      SRC_G2:  return gain_q[2];
      SRC_G3:  return gain_q[3];
      SRC_P0:  return cov_q[0];
      SRC_P1:  return cov_q[1];
      SRC_P2:  return cov_q[2];
      SRC_P3:  return cov_q[3];
      SRC_R0:  return {1'b0, cfg_rxx_q};
      SRC_R1:  return cfg_rxy_q;
      SRC_R2:  return cfg_ryx_q;
      SRC_R3:  return {1'b0, cfg_ryy_q};
      SRC_ST:  return {1'b0, cfg_step_q};
      SRC_A0:  return a_q[0];
      SRC_A1:  return a_q[1];
      SRC_A2:  return a_q[2];
      SRC_A3:  return a_q[3];
      SRC_DET: return det_q;
      SRC_N0:  return num_q[0];
      SRC_N1:  return num_q[1];
      SRC_N2:  return num_q[2];
      SRC_N3:  return num_q[3];
      default: return '0;
    endcase
  endfunction

  // registers only change between requests
  assign cfg_ready_o = state_q == S_IDLE;
  assign in_ready_o  = state_q == S_IDLE;

  always_comb begin
    jb       = job_of(job_q);
    mul_a    = pick(pidx_q ? jb.p1a : jb.p0a);
    mul_b    = pick(pidx_q ? jb.p1b : jb.p0b);
    pneg     = pidx_q ? jb.p1neg : jb.p0neg;
    prod_ext = pneg ? -AW'(mul_res) : AW'(mul_res);
    init_sum = AW'(pick(jb.ia)) + (jb.ib_neg ? -AW'(pick(jb.ib)) : AW'(pick(jb.ib)));
    // velocity is twice the step between measurements
    dvx      = (AW'(mx_q) - AW'(last_x_q)) <<< 1;
    dvy      = (AW'(my_q) - AW'(last_y_q)) <<< 1;
    // forward goal, dropped inside the deadband or on a repeated x measurement
    gdiff    = (W+1)'(mx_q) - $signed({2'b00, cfg_stand_q});
    if (gdiff < $signed({2'b00, cfg_dead_q}) || mx_q == last_x_q) begin
      goal = '0;
    end else begin
      goal = gdiff[W-2:0];
    end
  end

  assign div_start = state_q == S_DIV_GO;

  ptk_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res),
    .sat_o (mul_sat)
  );

  ptk_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q[div_k_q]),
    .den_i   (det_q),
    .done_o  (div_done),
    .res_o   (div_res),
    .sat_o   (div_sat)
  );

  // configuration registers, index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rxx_q   <= (W-1)'(TENTH_I);
      cfg_rxy_q   <= '0;
      cfg_ryx_q   <= '0;
      cfg_ryy_q   <= (W-1)'(TENTH_I);
      cfg_step_q  <= (W-1)'(ONE_I);
      cfg_stand_q <= (W-1)'(HALF5_I);
      cfg_close_q <= (W-1)'(QUART3_I);
      cfg_dead_q  <= (W-1)'(FIFTH_I);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_R_XX:     cfg_rxx_q   <= cfg_data_i[W-2:0];
        CFG_R_XY:     cfg_rxy_q   <= cfg_data_i;
        CFG_R_YX:     cfg_ryx_q   <= cfg_data_i;
        CFG_R_YY:     cfg_ryy_q   <= cfg_data_i[W-2:0];
        CFG_STEP:     cfg_step_q  <= cfg_data_i[W-2:0];
        CFG_STANDOFF: cfg_stand_q <= cfg_data_i[W-2:0];
        CFG_CLOSE:    cfg_close_q <= cfg_data_i[W-2:0];
        CFG_DEADBAND: cfg_dead_q  <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  // sequencer: jobs 0..14 (predict, correct, numerators), four divisions,
  // then jobs 15..18 (new covariance)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      est_x_q     <= W'(HALF5_I);
      est_y_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      seen_q      <= 1'b0;
      gain_q[0]   <= '0;
      gain_q[1]   <= '0;
      gain_q[2]   <= '0;
      gain_q[3]   <= '0;
      cov_q[0]    <= ONE_W;
      cov_q[1]    <= '0;
      cov_q[2]    <= '0;
      cov_q[3]    <= ONE_W;
      job_q       <= '0;
      pidx_q      <= 1'b0;
      div_k_q     <= '0;
      sat_q       <= 1'b0;
    end else begin
      // in S_DONE the new result takes the register in the same edge
      if (out_valid_o && out_ready_i && state_q != S_DONE) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mx_q    <= meas_x_i;
            my_q    <= meas_y_i;
            sat_q   <= 1'b0;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          vx_q    <= seen_q ? clip(dvx) : '0;
          vy_q    <= seen_q ? clip(dvy) : '0;
          sat_q   <= seen_q && (over(dvx) || over(dvy));
          job_q   <= '0;
          state_q <= S_INIT;
        end
        S_INIT: begin
          acc_q   <= init_sum;
          pidx_q  <= 1'b0;
          state_q <= (jb.nprod == 2'd0) ? S_WRITE : S_MUL;
        end
        S_MUL: begin
          // operands sit on the multiplier, product registered this edge
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_q + prod_ext;
          sat_q <= sat_q | mul_sat;
          if (!pidx_q && jb.nprod == 2'd2) begin
            pidx_q  <= 1'b1;
            state_q <= S_MUL;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          sat_q <= sat_q | over(acc_q);
          case (jb.dst)
            SRC_XP:  xp_q     <= clip(acc_q);
            SRC_YP:  yp_q     <= clip(acc_q);
            SRC_IX:  ix_q     <= clip(acc_q);
            SRC_IY:  iy_q     <= clip(acc_q);
            SRC_EX:  est_x_q  <= clip(acc_q);
            SRC_EY:  est_y_q  <= clip(acc_q);
            SRC_A0:  a_q[0]   <= clip(acc_q);
            SRC_A1:  a_q[1]   <= clip(acc_q);
            SRC_A2:  a_q[2]   <= clip(acc_q);
            SRC_A3:  a_q[3]   <= clip(acc_q);
            SRC_DET: det_q    <= clip(acc_q);
            SRC_N0:  num_q[0] <= clip(acc_q);
            SRC_N1:  num_q[1] <= clip(acc_q);
            SRC_N2:  num_q[2] <= clip(acc_q);
            SRC_N3:  num_q[3] <= clip(acc_q);
            SRC_P0:  cov_q[0] <= clip(acc_q);
            SRC_P1:  cov_q[1] <= clip(acc_q);
            SRC_P2:  cov_q[2] <= clip(acc_q);
            SRC_P3:  cov_q[3] <= clip(acc_q);
            default: ;
          endcase
          if (job_q == JOB_LAST_PRE) begin
            div_k_q <= '0;
            state_q <= S_DIV_GO;
          end else if (job_q == JOB_LAST) begin
            state_q <= S_DONE;
          end else begin
            job_q   <= job_q + 1'b1;
            state_q <= S_INIT;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            gain_q[div_k_q] <= div_res;
            sat_q           <= sat_q | div_sat;
            if (div_k_q == 2'd3) begin
              job_q   <= JOB_FIRST_POST;
              state_q <= S_INIT;
            end else begin
              div_k_q <= div_k_q + 1'b1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_DONE: begin
          // hold here only while an earlier result is still waiting
          if (!out_valid_o || out_ready_i) begin
            est_x_o        <= est_x_q;
            est_y_o        <= est_y_q;
            goal_forward_o <= goal;
            too_close_o    <= est_x_q < $signed({1'b0, cfg_close_q});
            saturated_o    <= sat_q;
            out_valid_o    <= 1'b1;
            last_x_q       <= mx_q;
            last_y_q       <= my_q;
            seen_q         <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/ptk_chk.sv
`include "assert_macros.svh"

module ptk_chk #(
  parameter int WORD_BITS = 32
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [WORD_BITS-1:0] est_x_o,
  input logic signed [WORD_BITS-1:0] est_y_o,
  input logic [WORD_BITS-2:0]        goal_forward_o,
  input logic                        too_close_o,
  input logic                        saturated_o
);

  // every result field side by side
  logic [3*WORD_BITS:0] out_bus;

  assign out_bus = {est_x_o, est_y_o, goal_forward_o, too_close_o, saturated_o};

  `PTK_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `PTK_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_bus), "stalled result changed")
  `PTK_ASSERT(a_busy_after_req, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after a request")
  `PTK_ASSERT(a_result_after_work, $rose(out_valid_o) |-> $past(!in_ready_o), "result without work")
  `PTK_NEVER(a_out_known, out_valid_o && $isunknown(out_bus), "unknown bits in a result")

endmodule

bind position_kalman_tracker_2d ptk_chk #(
  .WORD_BITS(WORD_BITS)
) u_ptk_chk (.*);
